>>> hdl/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg: shared types and constants of the positional list engine
// Holds the list capacity, the request and status codes, the sequencer
// states and the request and response payload structs.
// ----------------------------------------------------------------------------
package ple_pkg;

  // List capacity and derived widths.
  localparam int unsigned Capacity = 16;
  localparam int unsigned AddrW    = $clog2(Capacity);
  localparam int unsigned CntW     = 5;
  localparam int unsigned ValW     = 32;

  // Request codes; the eighth code is answered with an ok status and changes nothing.
  typedef enum logic [2:0] {
    ReqInsFront = 3'd0,
    ReqInsBack  = 3'd1,
    ReqRemFront = 3'd2,
    ReqRemBack  = 3'd3,
    ReqReadAt   = 3'd4,
    ReqInsAt    = 3'd5,
    ReqRemAt    = 3'd6
  } req_e;

  // Result status codes.
  typedef enum logic [1:0] {
    StatOk     = 2'd0,
    StatEmpty  = 2'd1,
    StatBadPos = 2'd2,
    StatFull   = 2'd3
  } status_e;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    SIdle = 4'b0001,
    SCapt = 4'b0010,
    SMvRd = 4'b0100,
    SMvWr = 4'b1000
  } state_e;

  // Request payload.
  typedef struct packed {
    logic [2:0]             req_type;
    logic [CntW-1:0]        position;
    logic signed [ValW-1:0] value_in;
  } req_t;

  // Response payload.
  typedef struct packed {
    logic signed [ValW-1:0] value_out;
    status_e                status;
    logic [CntW-1:0]        entry_count;
  } rsp_t;

endpackage

>>> hdl/ple_ram.sv
// ----------------------------------------------------------------------------
// ple_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ple_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> hdl/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine: bounded ordered list of signed 32-bit values
// Inserts, removes and reads at the front, the back or a given position.
// ----------------------------------------------------------------------------
// Usage:
//   A request transfers on req_i at a rising edge with start high and busy
//   low. Each request gives exactly one response on rsp_o, shown for one
//   cycle with valid_o high; the receiver cannot stall it.
//   Entries live in a single-port-pair RAM. One index unit (an add of plus
//   or minus one and a compare) steps a sequencer that moves one entry at a
//   time: a RAM read, then a write at the neighboring address.
//   Errors and the unused request code are answered straight from idle, and
//   busy never rises. A read at position captures the RAM data in SCapt. An
//   insert moves each later entry back (SMvRd, SMvWr) and then writes the new
//   value; a remove captures the entry in SCapt and then moves later entries.
//   Busy falls in the cycle the response is shown, and the next request may
//   transfer in that cycle.
//   Reset clears the entry count and the sequencer; the RAM is not cleared,
//   since only entries below the count are ever read.
// ----------------------------------------------------------------------------
module positional_list_engine (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  ple_pkg::req_t  req_i,
  output logic           valid_o,
  output ple_pkg::rsp_t  rsp_o
);

  localparam int unsigned AddrW = ple_pkg::AddrW;
  localparam int unsigned CntW  = ple_pkg::CntW;
  localparam int unsigned ValW  = ple_pkg::ValW;

  ple_pkg::state_e        state_q, state_d;
  logic [CntW-1:0]        count_q, count_d;
  logic [CntW-1:0]        idx_q, idx_d;
  logic [CntW-1:0]        pos_q, pos_d;
  logic [ValW-1:0]        val_q, val_d;
  logic                   up_q, up_d;
  logic                   rd_only_q, rd_only_d;
  logic                   valid_q, valid_d;
  ple_pkg::rsp_t          rsp_q, rsp_d;

  logic                   accept;
  logic [CntW-1:0]        eff_pos;
  ple_pkg::status_e       dec_status;
  logic                   dec_read, dec_remove, dec_insert;
  logic [CntW-1:0]        nbr;
  logic                   more;

  logic                   ram_we, ram_re;
  logic [AddrW-1:0]       ram_waddr, ram_raddr;
  logic [ValW-1:0]        ram_wdata, ram_rdata;

  assign accept  = start && !busy;
  assign busy    = (state_q != ple_pkg::SIdle);
  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

  // Request decode: effective position, error status and operation kind.
  always_comb begin
    eff_pos    = req_i.position;
    dec_status = ple_pkg::StatOk;
    dec_read   = 1'b0;
    dec_remove = 1'b0;
    dec_insert = 1'b0;
    unique case (req_i.req_type) inside
      ple_pkg::ReqInsFront, ple_pkg::ReqInsBack, ple_pkg::ReqInsAt: begin
        if (req_i.req_type == ple_pkg::ReqInsFront) begin
          eff_pos = '0;
        end else if (req_i.req_type == ple_pkg::ReqInsBack) begin
          eff_pos = count_q;
        end
        if (eff_pos > count_q) begin
          dec_status = ple_pkg::StatBadPos;
        end else if (count_q == CntW'(ple_pkg::Capacity)) begin
          dec_status = ple_pkg::StatFull;
        end else begin
          dec_insert = 1'b1;
        end
      end
      ple_pkg::ReqRemFront, ple_pkg::ReqRemBack, ple_pkg::ReqRemAt: begin
        if (req_i.req_type == ple_pkg::ReqRemFront) begin
          eff_pos = '0;
        end else if (req_i.req_type == ple_pkg::ReqRemBack) begin
          eff_pos = count_q - CntW'(1);
        end
        if (count_q == '0) begin
          dec_status = ple_pkg::StatEmpty;
        end else if (eff_pos >= count_q) begin
          dec_status = ple_pkg::StatBadPos;
        end else begin
          dec_remove = 1'b1;
        end
      end
      ple_pkg::ReqReadAt: begin
        if (eff_pos >= count_q) begin
          dec_status = ple_pkg::StatBadPos;
        end else begin
          dec_read = 1'b1;
        end
      end
      default: begin
        // The unused code is answered with an ok status and no change.
      end
    endcase
  end

  // Shared index unit: neighbor address and whether another move is due.
  assign nbr  = up_q ? (idx_q - CntW'(1)) : (idx_q + CntW'(1));
  assign more = up_q ? (idx_q != pos_q) : (nbr < count_q);

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    pos_d     = pos_q;
    val_d     = val_q;
    up_d      = up_q;
    rd_only_d = rd_only_q;
    valid_d   = 1'b0;
    rsp_d     = rsp_q;
    ram_we    = 1'b0;
    ram_waddr = idx_q[AddrW-1:0];
    ram_wdata = val_q;
    ram_re    = 1'b0;
    ram_raddr = nbr[AddrW-1:0];
    unique case (state_q)
      ple_pkg::SIdle: begin
        if (accept) begin
          pos_d = eff_pos;
          if (dec_read || dec_remove) begin
            ram_re    = 1'b1;
            ram_raddr = eff_pos[AddrW-1:0];
            up_d      = 1'b0;
            rd_only_d = dec_read;
            state_d   = ple_pkg::SCapt;
          end else if (dec_insert) begin
            idx_d   = count_q;
            val_d   = req_i.value_in;
            up_d    = 1'b1;
            state_d = ple_pkg::SMvRd;
          end else begin
            valid_d           = 1'b1;
            rsp_d.value_out   = '0;
            rsp_d.status      = dec_status;
            rsp_d.entry_count = count_q;
          end
        end
      end
      ple_pkg::SCapt: begin
        if (rd_only_q) begin
          valid_d           = 1'b1;
          rsp_d.value_out   = ram_rdata;
          rsp_d.status      = ple_pkg::StatOk;
          rsp_d.entry_count = count_q;
          state_d           = ple_pkg::SIdle;
        end else begin
          val_d   = ram_rdata;
          idx_d   = pos_q;
          state_d = ple_pkg::SMvRd;
        end
      end
      ple_pkg::SMvRd: begin
        if (more) begin
          ram_re  = 1'b1;
          state_d = ple_pkg::SMvWr;
        end else if (up_q) begin
          // Gap is open at the insert position: place the new value.
          ram_we            = 1'b1;
          count_d           = count_q + CntW'(1);
          valid_d           = 1'b1;
          rsp_d.value_out   = '0;
          rsp_d.status      = ple_pkg::StatOk;
          rsp_d.entry_count = count_q + CntW'(1);
          state_d           = ple_pkg::SIdle;
        end else begin
          count_d           = count_q - CntW'(1);
          valid_d           = 1'b1;
          rsp_d.value_out   = val_q;
          rsp_d.status      = ple_pkg::StatOk;
          rsp_d.entry_count = count_q - CntW'(1);
          state_d           = ple_pkg::SIdle;
        end
      end
      ple_pkg::SMvWr: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        idx_d     = nbr;
        state_d   = ple_pkg::SMvRd;
      end
      default: begin
        state_d = ple_pkg::SIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ple_pkg::SIdle;
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      valid_q <= valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    pos_q     <= pos_d;
    val_q     <= val_d;
    up_q      <= up_d;
    rd_only_q <= rd_only_d;
    rsp_q     <= rsp_d;
  end

  // Entry storage.
  ple_ram #(
    .Width(ValW),
    .Depth(ple_pkg::Capacity)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // A response is only shown once the sequencer has returned to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) valid_o |-> !busy)
    else $error("response strobe while the sequencer is busy");

  // The entry count never exceeds the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(ple_pkg::Capacity))
    else $error("entry count above capacity");

  // The count changes only together with a response.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> valid_o)
    else $error("entry count changed without a response");

  // The reported count matches the stored count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (rsp_o.entry_count == count_q))
    else $error("reported entry count differs from stored count");

  // An error response carries a zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (rsp_o.status != ple_pkg::StatOk)) |-> (rsp_o.value_out == '0))
    else $error("error response with a nonzero value");

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the positional list engine
// A queue of requests, filled up front, feeds a clocked driver. A clocked
// monitor predicts each transferred request against its own copy of the list
// and checks every response field against the oldest prediction. A directed
// opening covers the list edges and error cases. Random traffic then swings
// between filling and draining the list under several sender idle rates.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int          RandItems  = 800;
  localparam int          CycleLimit = 400000;
  localparam int          TailCycles = 60;
  localparam logic [2:0]  ReqUnused  = 3'd7;

  typedef struct {
    ple_pkg::req_t req;
    bit            hold_for_drain;
  } stim_t;

  logic          clk_i;
  logic          rst_ni;
  logic          start;
  logic          busy;
  ple_pkg::req_t req;
  logic          valid_o;
  ple_pkg::rsp_t rsp;

  // Pending requests, predicted responses and bookkeeping.
  stim_t         stim_q[$];
  ple_pkg::rsp_t list_rsp_q[$];
  int            rsp_pending;
  int            stim_total;
  int            sent_cnt;
  int            rsp_cnt;
  int            err_cnt;
  int            cycle_cnt;
  int            status_seen[4];
  int            gen_len;

  // Predicted list contents.
  logic signed [ple_pkg::ValW-1:0] list_mem[ple_pkg::Capacity];
  int unsigned                     list_len;

  positional_list_engine dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .req_i   (req),
    .valid_o (valid_o),
    .rsp_o   (rsp)
  );

  // Clock.
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Cycle counter and watchdog.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    err_cnt++;
    if (err_cnt <= 100) $display("MISMATCH cycle %0d: %s", cycle_cnt, what);
  endtask

  // Insert at a position, shifting later entries toward the back.
  function automatic ple_pkg::status_e list_insert(
      input int unsigned at, input logic signed [ple_pkg::ValW-1:0] v);
    int unsigned i;
    if (at > list_len) return ple_pkg::StatBadPos;
    if (list_len >= ple_pkg::Capacity) return ple_pkg::StatFull;
    for (i = list_len; i > at; i--) list_mem[i] = list_mem[i-1];
    list_mem[at] = v;
    list_len++;
    return ple_pkg::StatOk;
  endfunction

  // Remove at a position, closing the gap; emptiness is checked first.
  function automatic ple_pkg::status_e list_remove(
      input int unsigned at, output logic signed [ple_pkg::ValW-1:0] v);
    int unsigned i;
    v = '0;
    if (list_len == 0) return ple_pkg::StatEmpty;
    if (at >= list_len) return ple_pkg::StatBadPos;
    v = list_mem[at];
    for (i = at; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
    list_len--;
    return ple_pkg::StatOk;
  endfunction

  // Apply one request to the predicted list and return its response.
  function automatic ple_pkg::rsp_t list_apply(input ple_pkg::req_t r);
    ple_pkg::rsp_t                   o;
    ple_pkg::status_e                st;
    logic signed [ple_pkg::ValW-1:0] got;
    int unsigned                     p;
    o   = '0;
    st  = ple_pkg::StatOk;
    got = '0;
    p   = r.position;
    case (r.req_type)
      ple_pkg::ReqInsFront: st = list_insert(0, r.value_in);
      ple_pkg::ReqInsBack:  st = list_insert(list_len, r.value_in);
      ple_pkg::ReqRemFront: st = list_remove(0, got);
      ple_pkg::ReqRemBack: begin
        if (list_len == 0) st = ple_pkg::StatEmpty;
        else st = list_remove(list_len - 1, got);
      end
      ple_pkg::ReqReadAt: begin
        if (p >= list_len) st = ple_pkg::StatBadPos;
        else got = list_mem[p];
      end
      ple_pkg::ReqInsAt:    st = list_insert(p, r.value_in);
      ple_pkg::ReqRemAt:    st = list_remove(p, got);
      default:     ;
    endcase
    if (st != ple_pkg::StatOk) got = '0;
    o.value_out   = got;
    o.status      = st;
    o.entry_count = list_len[ple_pkg::CntW-1:0];
    return o;
  endfunction

  // Queue one request and track the list length it leaves behind.
  task automatic add_item(input logic [2:0] kind, input int pos,
                          input logic [ple_pkg::ValW-1:0] v, input bit drain);
    stim_t s;
    s.req.req_type   = kind;
    s.req.position   = pos[ple_pkg::CntW-1:0];
    s.req.value_in   = v;
    s.hold_for_drain = drain;
    stim_q.push_back(s);
    case (kind) inside
      ple_pkg::ReqInsFront, ple_pkg::ReqInsBack:
        if (gen_len < ple_pkg::Capacity) gen_len++;
      ple_pkg::ReqInsAt:
        if (pos <= gen_len && gen_len < ple_pkg::Capacity) gen_len++;
      ple_pkg::ReqRemFront, ple_pkg::ReqRemBack: if (gen_len > 0) gen_len--;
      ple_pkg::ReqRemAt: if (gen_len > 0 && pos < gen_len) gen_len--;
      default: ;
    endcase
  endtask

  // Driver: presents queued requests, idling at the rate of the current phase.
  always @(posedge clk_i or negedge rst_ni) begin : driver
    bit taken;
    bit launch;
    int idle_pct;
    if (!rst_ni) begin
      start <= 1'b0;
      req   <= '0;
    end else begin
      taken  = start && !busy;
      launch = 1'b0;
      if (taken) begin
        void'(stim_q.pop_front());
        sent_cnt++;
      end
      if (sent_cnt < stim_total / 3) idle_pct = 21;
      else if (sent_cnt < 2 * stim_total / 3) idle_pct = 45;
      else idle_pct = 0;
      if (stim_q.size() != 0) begin
        if (start && !taken) begin
          // Keep presenting the same request until it transfers.
          launch = 1'b1;
        end else if (stim_q[0].hold_for_drain && (start || rsp_pending != 0)) begin
          // Hold off until every outstanding response has come back.
          launch = 1'b0;
        end else begin
          launch = ($urandom_range(99) >= idle_pct);
        end
      end
      start <= launch;
      if (launch) req <= stim_q[0].req;
    end
  end

  // Monitor: predicts transferred requests and checks each response.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    ple_pkg::rsp_t want;
    if (!rst_ni) begin
      rsp_pending <= 0;
    end else begin
      if (valid_o) begin
        rsp_cnt++;
        if (list_rsp_q.size() == 0) begin
          report_mismatch("response with no request outstanding");
        end else begin
          want = list_rsp_q.pop_front();
          status_seen[want.status]++;
          if (rsp.value_out !== want.value_out)
            report_mismatch($sformatf("value_out got %0d want %0d",
                                      rsp.value_out, want.value_out));
          if (rsp.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      rsp.status, want.status));
          if (rsp.entry_count !== want.entry_count)
            report_mismatch($sformatf("entry_count got %0d want %0d",
                                      rsp.entry_count, want.entry_count));
        end
      end
      if (start && !busy) list_rsp_q.push_back(list_apply(req));
      rsp_pending <= list_rsp_q.size();
    end
  end

  // Stimulus, reset and end of run.
  initial begin : stimulus
    int          kind_pick;
    int          ins_pct;
    int          rem_pct;
    int          pos;
    logic [2:0]  kind;
    logic [31:0] v;
    rst_ni      = 1'b0;
    cycle_cnt   = 0;
    sent_cnt    = 0;
    rsp_cnt     = 0;
    err_cnt     = 0;
    gen_len     = 0;
    list_len    = 0;
    stim_total  = 0;
    status_seen = '{default: 0};

    // Errors on an empty list, then a short list built from the value extremes.
    add_item(ple_pkg::ReqReadAt,   0,  32'h0,        1'b0);
    add_item(ple_pkg::ReqRemFront, 0,  32'h0,        1'b0);
    add_item(ple_pkg::ReqRemBack,  0,  32'h0,        1'b0);
    add_item(ple_pkg::ReqRemAt,    31, 32'h0,        1'b0);
    add_item(ple_pkg::ReqInsAt,    1,  32'h1234,     1'b0);
    add_item(ple_pkg::ReqInsFront, 0,  32'h80000000, 1'b0);
    add_item(ple_pkg::ReqInsBack,  31, 32'h7fffffff, 1'b0);
    add_item(ple_pkg::ReqInsAt,    1,  32'hffffffff, 1'b0);
    add_item(ple_pkg::ReqInsAt,    2,  32'h0,        1'b0);
    add_item(ple_pkg::ReqReadAt,   3,  32'h0,        1'b0);
    add_item(ple_pkg::ReqReadAt,   4,  32'h0,        1'b0);
    add_item(ple_pkg::ReqReadAt,   31, 32'h0,        1'b0);
    add_item(ple_pkg::ReqRemAt,    4,  32'h0,        1'b0);
    add_item(ReqUnused,            31, 32'hffffffff, 1'b0);
    add_item(ple_pkg::ReqInsAt,    5,  32'h55aa55aa, 1'b0);
    add_item(ple_pkg::ReqRemAt,    1,  32'h0,        1'b1);
    add_item(ple_pkg::ReqRemBack,  0,  32'h0,        1'b0);
    add_item(ple_pkg::ReqRemFront, 0,  32'h0,        1'b0);
    add_item(ple_pkg::ReqReadAt,   0,  32'h0,        1'b0);
    add_item(ple_pkg::ReqRemAt,    0,  32'h0,        1'b0);

    // Random traffic in segments that lean toward filling, draining or neither.
    ins_pct = 70;
    rem_pct = 15;
    for (int n = 0; n < RandItems; n++) begin
      if (n % 50 == 0 && n != 0) begin
        case ($urandom_range(2))
          0: begin ins_pct = 70; rem_pct = 15; end
          1: begin ins_pct = 15; rem_pct = 70; end
          default: begin ins_pct = 40; rem_pct = 40; end
        endcase
      end
      kind_pick = $urandom_range(99);
      if (kind_pick < ins_pct) begin
        case ($urandom_range(2))
          0: kind = ple_pkg::ReqInsFront;
          1: kind = ple_pkg::ReqInsBack;
          default: kind = ple_pkg::ReqInsAt;
        endcase
      end else if (kind_pick < ins_pct + rem_pct) begin
        case ($urandom_range(2))
          0: kind = ple_pkg::ReqRemFront;
          1: kind = ple_pkg::ReqRemBack;
          default: kind = ple_pkg::ReqRemAt;
        endcase
      end else if (kind_pick < 97) begin
        kind = ple_pkg::ReqReadAt;
      end else begin
        kind = ReqUnused;
      end
      // Mostly positions that land inside the list, sometimes any code.
      if ($urandom_range(99) < 85) begin
        if (kind == ple_pkg::ReqInsAt) pos = $urandom_range(gen_len);
        else pos = (gen_len == 0) ? 0 : $urandom_range(gen_len - 1);
      end else begin
        pos = $urandom_range(31);
      end
      case ($urandom_range(19))
        0: v = 32'h80000000;
        1: v = 32'h7fffffff;
        2: v = 32'hffffffff;
        3: v = 32'h0;
        default: v = $urandom;
      endcase
      add_item(kind, pos, v, (n % 97 == 0));
    end
    stim_total = stim_q.size();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every request to transfer and every response to return.
    @(negedge clk_i);
    while (stim_q.size() != 0 || start || list_rsp_q.size() != 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);
    if (list_rsp_q.size() != 0)
      report_mismatch($sformatf("%0d responses never arrived", list_rsp_q.size()));

    $display("Sent %0d requests, checked %0d responses in %0d cycles.",
             sent_cnt, rsp_cnt, cycle_cnt);
    $display("Status mix: ok %0d, empty %0d, bad position %0d, full %0d.",
             status_seen[ple_pkg::StatOk], status_seen[ple_pkg::StatEmpty],
             status_seen[ple_pkg::StatBadPos], status_seen[ple_pkg::StatFull]);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/ple_pkg.sv
hdl/ple_ram.sv
hdl/positional_list_engine.sv
verif/tb_top.sv
